### rtl/cacc_pkg.sv
// ----------------------------------------------------------------------------
// cacc_pkg
// shared types, register indexes and constants of the platoon speed controller
// ----------------------------------------------------------------------------
package cacc_pkg;

	// fixed-point widths
	localparam int SPEED_W  = 16;
	localparam int GAP_W    = 18;
	localparam int GAIN_W   = 16;
	localparam int C1_W     = 13;
	localparam int LIMIT_W  = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	// shared multiplier and accumulator
	localparam int OPA_W  = 22;
	localparam int OPB_W  = 19;
	localparam int PROD_W = OPA_W + OPB_W;

	localparam logic [C1_W-1:0]  ONE_Q12     = 13'd4096;
	localparam logic [16:0]      ONE_Q16     = 17'h10000;
	localparam logic [GAP_W-1:0] STOP_GAP    = 18'd3;
	// x / 10 as (x * 52429) >> 19, exact for x below 2^18
	localparam logic [OPB_W-1:0] RECIP10     = 19'd52429;
	localparam int               RECIP10_SH  = 19;
	// eng + 5 offset by 3277 * 10 so the quotient input is non-negative
	localparam logic [16:0]      DIV_OFFSET  = 17'd32775;
	localparam logic [17:0]      DIV_UNBIAS  = 18'd3277;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_C1          = 3'd0,
		REG_GAIN_SPEED  = 3'd1,
		REG_GAIN_LEADER = 3'd2,
		REG_GAIN_GAP    = 3'd3,
		REG_ALPHA       = 3'd4,
		REG_MAX_ACCEL   = 3'd5,
		REG_MAX_DECEL   = 3'd6,
		REG_DESIRED_GAP = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic                     command;
		logic [GAP_W-1:0]         gap;
		logic [SPEED_W-1:0]       ego_speed;
		logic [SPEED_W-1:0]       pred_speed;
		logic [SPEED_W-1:0]       leader_speed;
	} meas_word_t;

	typedef struct packed {
		logic [SPEED_W-1:0]        next_speed;
		logic signed [SPEED_W-1:0] engine_accel;
	} spd_word_t;

	typedef struct packed {
		logic [C1_W-1:0]          c1;
		logic signed [GAIN_W-1:0] gain_speed_error;
		logic signed [GAIN_W-1:0] gain_leader_speed;
		logic signed [GAIN_W-1:0] gain_gap_error;
		logic [15:0]              filter_alpha;
		logic [LIMIT_W-1:0]       max_accel;
		logic [LIMIT_W-1:0]       max_decel;
		logic [GAP_W-1:0]         desired_gap;
	} cfg_t;

	// operand pair fed to the shared multiplier
	typedef enum logic [3:0] {
		MS_NONE,
		MS_W_PRED,
		MS_W_LEAD,
		MS_GAIN_SPEED,
		MS_GAIN_LEADER,
		MS_GAIN_GAP,
		MS_ALPHA,
		MS_BETA,
		MS_RECIP
	} mul_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_CLAMP,
		ST_F0,
		ST_F1,
		ST_ENG,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		mul_sel_t sel;
		logic     load_in;
		logic     acc_first;
		logic     acc_add;
		logic     ld_acc;
		logic     ld_eng;
		logic     fin;
	} dp_cmd_t;

	typedef struct packed {
		logic zero_case;
		logic out_busy;
	} dp_status_t;

endpackage

### rtl/cacc_speed_controller.sv
// ----------------------------------------------------------------------------
// cacc_speed_controller
// constant-spacing platoon speed controller, one word per control tick
// ----------------------------------------------------------------------------
// usage:
//   meas channel (meas_valid / meas_stall / meas) carries one tick's gap,
//   own, predecessor and leader speeds; it is taken when valid is high and
//   stall is low. spd channel (spd_valid / spd_stall / spd) returns the next
//   commanded speed and the filtered engine acceleration, one word per tick.
//   cfg_we / cfg_index / cfg_data write the gain and limit registers; write
//   only while no tick is in flight.
// sequencing:
//   the next word can be taken only once the result of the last one is
//   loaded; the pace is set by the single shared multiplier, which is stepped
//   through seven products plus the divide-by-ten reciprocal product, with
//   clamp, rounding and output steps in between.
//   a stop word with a gap under 0.01 m skips the arithmetic and goes from
//   idle straight to the output step.
// reset:
//   arst_n clears the stored speeds and acceleration to zero and loads the
//   register defaults; the block is ready for a word right after reset.
// stall:
//   the output register holds a finished word while spd_stall is high; the
//   next word is still taken and computed, and waits in its last step until
//   the output register is free.
// ----------------------------------------------------------------------------
module cacc_speed_controller import cacc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// measurement words in
	input  logic                  meas_valid,
	output logic                  meas_stall,
	input  meas_word_t            meas,
	// speed command words out
	output logic                  spd_valid,
	input  logic                  spd_stall,
	output spd_word_t             spd,
	// register writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	// gain, weight, filter and limit registers
	cacc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer: one product per cycle, then clamp, filter and speed step
	cacc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.meas_valid (meas_valid),
		.meas_stall (meas_stall),
		.status     (status),
		.cmd        (cmd)
	);

	// arithmetic, tick state and output register
	cacc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.meas      (meas),
		.cmd       (cmd),
		.status    (status),
		.spd_valid (spd_valid),
		.spd_stall (spd_stall),
		.spd       (spd)
	);

endmodule

### rtl/cacc_cfg.sv
// ----------------------------------------------------------------------------
// cacc_cfg
// configuration register file with reset values and index decode
// ----------------------------------------------------------------------------
module cacc_cfg import cacc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.c1                <= 13'd2048;
			cfg_q.gain_speed_error  <= -16'sd1229;
			cfg_q.gain_leader_speed <= -16'sd410;
			cfg_q.gain_gap_error    <= -16'sd164;
			cfg_q.filter_alpha      <= 16'd10923;
			cfg_q.max_accel         <= 15'd384;
			cfg_q.max_decel         <= 15'd1536;
			cfg_q.desired_gap       <= 18'd3840;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_C1:          cfg_q.c1                <= cfg_data[C1_W-1:0];
				REG_GAIN_SPEED:  cfg_q.gain_speed_error  <= cfg_data[GAIN_W-1:0];
				REG_GAIN_LEADER: cfg_q.gain_leader_speed <= cfg_data[GAIN_W-1:0];
				REG_GAIN_GAP:    cfg_q.gain_gap_error    <= cfg_data[GAIN_W-1:0];
				REG_ALPHA:       cfg_q.filter_alpha      <= cfg_data[15:0];
				REG_MAX_ACCEL:   cfg_q.max_accel         <= cfg_data[LIMIT_W-1:0];
				REG_MAX_DECEL:   cfg_q.max_decel         <= cfg_data[LIMIT_W-1:0];
				REG_DESIRED_GAP: cfg_q.desired_gap       <= cfg_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/cacc_ctrl.sv
// ----------------------------------------------------------------------------
// cacc_ctrl
// sequencer stepping the shared multiplier through one control tick
// ----------------------------------------------------------------------------
module cacc_ctrl import cacc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       meas_valid,
	output logic       meas_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.sel    = MS_NONE;
		meas_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				meas_stall = 1'b0;
				if (meas_valid) begin
					cmd.load_in = 1'b1;
					state_d     = status.zero_case ? ST_FIN : ST_M0;
				end
			end
			ST_M0: begin
				cmd.sel = MS_W_PRED;
				state_d = ST_M1;
			end
			ST_M1: begin
				cmd.sel       = MS_W_LEAD;
				cmd.acc_first = 1'b1;
				state_d       = ST_M2;
			end
			ST_M2: begin
				cmd.sel     = MS_GAIN_SPEED;
				cmd.acc_add = 1'b1;
				state_d     = ST_M3;
			end
			ST_M3: begin
				cmd.sel     = MS_GAIN_LEADER;
				cmd.acc_add = 1'b1;
				state_d     = ST_M4;
			end
			ST_M4: begin
				cmd.sel     = MS_GAIN_GAP;
				cmd.acc_add = 1'b1;
				state_d     = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.ld_acc = 1'b1;
				state_d    = ST_F0;
			end
			ST_F0: begin
				cmd.sel = MS_ALPHA;
				state_d = ST_F1;
			end
			ST_F1: begin
				cmd.sel       = MS_BETA;
				cmd.acc_first = 1'b1;
				state_d       = ST_ENG;
			end
			ST_ENG: begin
				cmd.ld_eng = 1'b1;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				cmd.sel = MS_RECIP;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				// keep the quotient product alive while the output is busy
				cmd.sel = MS_RECIP;
				if (!status.out_busy) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### rtl/cacc_dp.sv
// ----------------------------------------------------------------------------
// cacc_dp
// datapath: input and state registers, shared multiplier, accumulator, output
// ----------------------------------------------------------------------------
module cacc_dp import cacc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  meas_word_t meas,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output logic       spd_valid,
	input  logic       spd_stall,
	output spd_word_t  spd
);

	// latched word
	logic [GAP_W-1:0]   gap_q;
	logic [SPEED_W-1:0] ego_q, pred_q, lead_q;
	logic               zero_q;

	// tick-to-tick state
	logic [SPEED_W-1:0]        last_pred_q, last_lead_q;
	logic signed [SPEED_W-1:0] last_eng_q;

	logic signed [PROD_W-1:0]  prod_q, accum_q;
	logic signed [SPEED_W-1:0] acc_q, eng_q;
	logic                      out_valid_q;
	spd_word_t                 out_q;

	logic signed [16:0]      d_pred, d_lead, e_pred, e_lead;
	logic signed [20:0]      x_pred, x_lead, pred_acc, lead_acc;
	logic signed [GAP_W:0]   gap_err;
	logic [C1_W-1:0]         w_lead, w_pred;
	logic [16:0]             beta, div_in;
	logic signed [OPA_W-1:0] op_a;
	logic signed [OPB_W-1:0] op_b;
	logic signed [PROD_W-1:0] sum_w, acc_round, eng_round, hi_lim, lo_lim;
	logic signed [SPEED_W-1:0] acc_d;
	logic [12:0]             quot;
	logic signed [17:0]      nxt;
	logic [SPEED_W-1:0]      nxt_sat;

	assign status.zero_case = meas.command && (meas.gap < STOP_GAP);
	assign status.out_busy  = out_valid_q && spd_stall;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			gap_q  <= meas.gap;
			ego_q  <= meas.ego_speed;
			pred_q <= meas.command ? '0 : meas.pred_speed;
			lead_q <= meas.leader_speed;
			zero_q <= status.zero_case;
		end
	end

	// speed differences and ten-per-second accelerations
	assign d_pred   = $signed({1'b0, pred_q}) - $signed({1'b0, last_pred_q});
	assign d_lead   = $signed({1'b0, lead_q}) - $signed({1'b0, last_lead_q});
	assign x_pred   = {{4{d_pred[16]}}, d_pred};
	assign x_lead   = {{4{d_lead[16]}}, d_lead};
	assign pred_acc = (x_pred <<< 3) + (x_pred <<< 1);
	assign lead_acc = (x_lead <<< 3) + (x_lead <<< 1);
	assign e_pred   = $signed({1'b0, ego_q}) - $signed({1'b0, pred_q});
	assign e_lead   = $signed({1'b0, ego_q}) - $signed({1'b0, lead_q});
	assign gap_err  = $signed({1'b0, cfg.desired_gap}) - $signed({1'b0, gap_q});
	assign w_lead   = (cfg.c1 > ONE_Q12) ? ONE_Q12 : cfg.c1;
	assign w_pred   = ONE_Q12 - w_lead;
	assign beta     = ONE_Q16 - {1'b0, cfg.filter_alpha};
	assign div_in   = {eng_q[15], eng_q} + DIV_OFFSET;

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.sel)
			MS_W_PRED: begin
				op_a = {pred_acc[20], pred_acc};
				op_b = {6'b0, w_pred};
			end
			MS_W_LEAD: begin
				op_a = {lead_acc[20], lead_acc};
				op_b = {6'b0, w_lead};
			end
			MS_GAIN_SPEED: begin
				op_a = {{5{e_pred[16]}}, e_pred};
				op_b = {{3{cfg.gain_speed_error[15]}}, cfg.gain_speed_error};
			end
			MS_GAIN_LEADER: begin
				op_a = {{5{e_lead[16]}}, e_lead};
				op_b = {{3{cfg.gain_leader_speed[15]}}, cfg.gain_leader_speed};
			end
			MS_GAIN_GAP: begin
				op_a = {{3{gap_err[18]}}, gap_err};
				op_b = {{3{cfg.gain_gap_error[15]}}, cfg.gain_gap_error};
			end
			MS_ALPHA: begin
				op_a = {{6{acc_q[15]}}, acc_q};
				op_b = {3'b0, cfg.filter_alpha};
			end
			MS_BETA: begin
				op_a = {{6{last_eng_q[15]}}, last_eng_q};
				op_b = {2'b0, beta};
			end
			MS_RECIP: begin
				op_a = {5'b0, div_in};
				op_b = RECIP10;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		if (cmd.acc_first) begin
			accum_q <= prod_q;
		end else if (cmd.acc_add) begin
			accum_q <= accum_q + prod_q;
		end
		if (cmd.ld_acc) begin
			acc_q <= acc_d;
		end
		if (cmd.ld_eng) begin
			eng_q <= eng_round[SPEED_W-1:0];
		end
	end

	// round, then clamp to [-max_decel, max_accel]
	assign sum_w     = accum_q + prod_q;
	assign acc_round = (sum_w + 41'sd2048) >>> 12;
	assign eng_round = (sum_w + 41'sd32768) >>> 16;
	assign hi_lim    = $signed({26'b0, cfg.max_accel});
	assign lo_lim    = -$signed({26'b0, cfg.max_decel});

	always_comb begin
		if (acc_round > hi_lim) begin
			acc_d = hi_lim[SPEED_W-1:0];
		end else if (acc_round < lo_lim) begin
			acc_d = lo_lim[SPEED_W-1:0];
		end else begin
			acc_d = acc_round[SPEED_W-1:0];
		end
	end

	// speed step: floor((eng + 5) / 10) added to own speed
	assign quot = prod_q[RECIP10_SH+12:RECIP10_SH];
	assign nxt  = $signed({2'b0, ego_q}) + $signed({5'b0, quot}) - $signed(DIV_UNBIAS);

	always_comb begin
		if (nxt < 0) begin
			nxt_sat = '0;
		end else if (nxt[17:16] != 2'b00) begin
			nxt_sat = '1;
		end else begin
			nxt_sat = nxt[SPEED_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pred_q <= '0;
			last_lead_q <= '0;
			last_eng_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
				if (!zero_q) begin
					last_pred_q <= pred_q;
					last_lead_q <= lead_q;
					last_eng_q  <= eng_q;
				end
			end else if (!spd_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_q.next_speed   <= zero_q ? '0 : nxt_sat;
			out_q.engine_accel <= zero_q ? '0 : eng_q;
		end
	end

	assign spd_valid = out_valid_q;
	assign spd       = out_q;

`ifndef NO_ASSERTIONS
	// a finished word never overwrites one still waiting downstream
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !(out_valid_q && spd_stall))
		else $error("result overwritten while stalled");

	// the result appears right after the sequencer finishes
	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> out_valid_q)
		else $error("result not presented after finish");

	// the clamped acceleration respects the limits when the filter uses it
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sel == MS_ALPHA) |->
			($signed({acc_q[15], acc_q}) <= $signed({2'b0, cfg.max_accel})) &&
			($signed({acc_q[15], acc_q}) >= -$signed({2'b0, cfg.max_decel})))
		else $error("clamped acceleration out of range");
`endif

endmodule

### tb/sv/cacc_speed_controller_tb.sv
// ----------------------------------------------------------------------------
// cacc_speed_controller_tb
// self-checking bench for the platoon speed controller
// ----------------------------------------------------------------------------
// measurement words go in from a queue through a bursty driver. Each word
// taken by the block runs through a local copy of the control law, which
// queues the speed word it should give back. A monitor compares every speed
// word leaving the block against the oldest queued one. Register settings
// change between phases, only while nothing is in flight.
// ----------------------------------------------------------------------------
module cacc_speed_controller_tb;
	import cacc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES = 12;
	localparam int STUCK_LIMIT  = 4000;   // cycles with no handshake at all
	localparam int HOLD_AT      = 150;    // result count that starts the long stall
	localparam int HOLD_CYCLES  = 500;
	localparam int TAIL_CYCLES  = 40;
	localparam int MAX_REPORTS  = 10;

	// register values after reset
	localparam int DEF_C1          = 2048;
	localparam int DEF_GAIN_SPEED  = -1229;
	localparam int DEF_GAIN_LEADER = -410;
	localparam int DEF_GAIN_GAP    = -164;
	localparam int DEF_ALPHA       = 10923;
	localparam int DEF_MAX_ACCEL   = 384;
	localparam int DEF_MAX_DECEL   = 1536;
	localparam int DEF_GAP         = 3840;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_COMB} stall_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  meas_valid = 1'b0;
	logic                  meas_stall;
	meas_word_t            meas = '0;
	logic                  spd_valid;
	logic                  spd_stall = 1'b0;
	spd_word_t             spd;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	cacc_speed_controller DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.meas_valid (meas_valid),
		.meas_stall (meas_stall),
		.meas       (meas),
		.spd_valid  (spd_valid),
		.spd_stall  (spd_stall),
		.spd        (spd),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// local copy of the registers and of the controller memory
	cfg_t               regs;
	logic [15:0]        last_pred = '0;
	logic [15:0]        last_lead = '0;
	logic signed [15:0] last_eng = '0;

	meas_word_t meas_todo[$];   // words waiting for the driver
	spd_word_t  cmd_due[$];     // speed words the block still owes

	int n_queued  = 0;
	int n_taken   = 0;
	int n_results = 0;
	int n_bad     = 0;

	// scenario state for the platoon-like random words
	int sim_lead = 5000;
	int sim_pred = 5000;
	int sim_ego  = 5000;

	// one control tick of the speed law; updates the controller memory
	function automatic spd_word_t control_tick(input meas_word_t m);
		longint ego, pred, lead, w_lead, sum, acc, eng, dv, nxt;
		spd_word_t r;
		r = '0;
		// stop word right at the obstacle: zero command, memory untouched
		if (m.command && m.gap < STOP_GAP)
			return r;
		ego  = longint'(m.ego_speed);
		pred = m.command ? 0 : longint'(m.pred_speed);
		lead = longint'(m.leader_speed);
		// leader weighting saturates at one
		w_lead = (regs.c1 > ONE_Q12) ? longint'(ONE_Q12) : longint'(regs.c1);
		// neighbour accelerations are ten times the speed change per tick
		sum = (longint'(ONE_Q12) - w_lead) * 10 * (pred - longint'(last_pred))
			+ w_lead * 10 * (lead - longint'(last_lead))
			+ longint'($signed(regs.gain_speed_error)) * (ego - pred)
			+ longint'($signed(regs.gain_leader_speed)) * (ego - lead)
			+ longint'($signed(regs.gain_gap_error))
				* (longint'(regs.desired_gap) - longint'(m.gap));
		// round Q12 product back to Q8.8, then clamp
		acc = (sum + 2048) >>> 12;
		if (acc > longint'(regs.max_accel))
			acc = longint'(regs.max_accel);
		if (acc < -longint'(regs.max_decel))
			acc = -longint'(regs.max_decel);
		// first-order engine lag
		eng = (longint'(regs.filter_alpha) * acc
			+ (longint'(ONE_Q16) - longint'(regs.filter_alpha)) * longint'(last_eng)
			+ 32768) >>> 16;
		// speed change over 0.1 s, floor division by ten on a biased value
		dv  = (eng + 5 + 3276800) / 10 - 327680;
		nxt = ego + dv;
		if (nxt < 0)
			nxt = 0;
		if (nxt > 65535)
			nxt = 65535;
		last_pred = pred[15:0];
		last_lead = lead[15:0];
		last_eng  = eng[15:0];
		r.next_speed   = nxt[15:0];
		r.engine_accel = eng[15:0];
		return r;
	endfunction

	function automatic int sat(input int v, input int hi);
		return (v < 0) ? 0 : ((v > hi) ? hi : v);
	endfunction

	// ------------------------------------------------------------------------
	// driver: bursts of words with random idle gaps between them
	// ------------------------------------------------------------------------
	int burst_left = 1;
	int idle_left  = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (meas_valid && !meas_stall) begin
				cmd_due.push_back(control_tick(meas));
				n_taken++;
			end
			// a stalled word stays put
			if (!(meas_valid && meas_stall)) begin
				if (idle_left > 0) begin
					idle_left--;
					meas_valid <= 1'b0;
				end else if (meas_todo.size() > 0) begin
					meas       <= meas_todo.pop_front();
					meas_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						// now and then a long burst with no gaps at all
						burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 24);
						idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					meas_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// receiver stall: a randomly picked stall mode, plus one long hold-off
	// ------------------------------------------------------------------------
	stall_mode_t stall_mode  = STALL_NONE;
	int          stall_clock = 0;
	int          hold_left   = 0;
	logic        hold_done   = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			stall_clock++;
			if (stall_clock % 64 == 0)
				stall_mode = stall_mode_t'($urandom_range(0, 3));
			// block fills up while the sender keeps offering words
			if (!hold_done && n_results >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				spd_stall <= 1'b1;
			end else begin
				case (stall_mode)
					STALL_NONE:  spd_stall <= 1'b0;
					STALL_LIGHT: spd_stall <= ($urandom_range(0, 7) == 0);
					STALL_HEAVY: spd_stall <= ($urandom_range(0, 1) == 0);
					default:     spd_stall <= (stall_clock % 3 == 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: each speed word against the oldest owed one
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_spd
		spd_word_t want;
		if (arst_n && spd_valid && !spd_stall) begin
			n_results++;
			if (cmd_due.size() == 0) begin
				n_bad++;
				if (n_bad <= MAX_REPORTS)
					$display("spd word with none owed: next_speed %0d engine_accel %0d",
						spd.next_speed, $signed(spd.engine_accel));
			end else begin
				want = cmd_due.pop_front();
				if (spd.next_speed !== want.next_speed
						|| spd.engine_accel !== want.engine_accel) begin
					n_bad++;
					if (n_bad <= MAX_REPORTS)
						$display("spd mismatch: want next_speed %0d engine_accel %0d, got %0d %0d",
							want.next_speed, $signed(want.engine_accel),
							spd.next_speed, $signed(spd.engine_accel));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: ends the run when no handshake happens for too long
	// ------------------------------------------------------------------------
	int quiet = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((meas_valid && !meas_stall) || (spd_valid && !spd_stall) || cfg_we)
				quiet = 0;
			else
				quiet++;
			if (quiet >= STUCK_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	task automatic add_meas(input logic cmd, input int unsigned gap_v, input int unsigned ego,
			input int unsigned pred, input int unsigned lead);
		meas_word_t m;
		m.command      = cmd;
		m.gap          = gap_v[GAP_W-1:0];
		m.ego_speed    = ego[15:0];
		m.pred_speed   = pred[15:0];
		m.leader_speed = lead[15:0];
		meas_todo.push_back(m);
		n_queued++;
	endtask

	// wait until every word is taken and every speed word is back
	task automatic settle();
		while (n_taken != n_queued || cmd_due.size() != 0)
			@(posedge clk);
	endtask

	// register write; bits above the register width carry random junk
	task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
		int unsigned mask;
		int          w;
		logic [CFG_DATA_W-1:0] word;
		case (idx)
			REG_C1:                      w = C1_W;
			REG_MAX_ACCEL, REG_MAX_DECEL: w = LIMIT_W;
			REG_DESIRED_GAP:             w = GAP_W;
			default:                     w = GAIN_W;
		endcase
		mask = (32'd1 << w) - 1;
		word = CFG_DATA_W'(($urandom & ~mask) | (val & mask));
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_C1:          regs.c1                = word[C1_W-1:0];
			REG_GAIN_SPEED:  regs.gain_speed_error  = word[15:0];
			REG_GAIN_LEADER: regs.gain_leader_speed = word[15:0];
			REG_GAIN_GAP:    regs.gain_gap_error    = word[15:0];
			REG_ALPHA:       regs.filter_alpha      = word[15:0];
			REG_MAX_ACCEL:   regs.max_accel         = word[LIMIT_W-1:0];
			REG_MAX_DECEL:   regs.max_decel         = word[LIMIT_W-1:0];
			default:         regs.desired_gap       = word[GAP_W-1:0];
		endcase
	endtask

	task automatic write_all(input int c1, input int gs, input int gl, input int gg,
			input int alpha, input int acc_hi, input int dec_hi, input int dgap);
		write_reg(REG_C1, c1);
		write_reg(REG_GAIN_SPEED, gs);
		write_reg(REG_GAIN_LEADER, gl);
		write_reg(REG_GAIN_GAP, gg);
		write_reg(REG_ALPHA, alpha);
		write_reg(REG_MAX_ACCEL, acc_hi);
		write_reg(REG_MAX_DECEL, dec_hi);
		write_reg(REG_DESIRED_GAP, dgap);
	endtask

	// mostly gentle negative gains, some positive, some anywhere in range
	function automatic int pick_gain();
		case ($urandom_range(0, 3))
			0, 1:    return -int'($urandom_range(0, 4000));
			2:       return $urandom_range(0, 4000);
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	task automatic random_regs();
		write_all(($urandom_range(0, 7) == 0) ? $urandom_range(4097, 8191) : $urandom_range(0, 4096),
			pick_gain(), pick_gain(), pick_gain(),
			$urandom_range(0, 65535),
			($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 2000),
			($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 2000),
			($urandom_range(0, 3) == 0) ? $urandom_range(0, 262143) : $urandom_range(0, 20000));
	endtask

	// mostly a drifting platoon, some raw noise, some stops near an obstacle
	task automatic random_ticks(input int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				sim_lead = sat(sim_lead + int'($urandom_range(0, 160)) - 80, 9000);
				sim_pred = sat(sim_lead + int'($urandom_range(0, 400)) - 200, 65535);
				sim_ego  = sat(sim_pred + int'($urandom_range(0, 600)) - 300, 65535);
				if ($urandom_range(0, 9) == 0)
					add_meas(1'b1, $urandom_range(0, 800), sim_ego, sim_pred, sim_lead);
				else
					add_meas(1'b0, sat(int'(regs.desired_gap) + int'($urandom_range(0, 4000)) - 2000,
						262143), sim_ego, sim_pred, sim_lead);
			end else if (pick < 85) begin
				add_meas(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom);
			end else begin
				add_meas(1'b1, $urandom_range(0, 6), $urandom_range(0, 9000), $urandom,
					$urandom_range(0, 9000));
			end
		end
		settle();
	endtask

	initial begin
		regs.c1                = C1_W'(DEF_C1);
		regs.gain_speed_error  = GAIN_W'(DEF_GAIN_SPEED);
		regs.gain_leader_speed = GAIN_W'(DEF_GAIN_LEADER);
		regs.gain_gap_error    = GAIN_W'(DEF_GAIN_GAP);
		regs.filter_alpha      = 16'(DEF_ALPHA);
		regs.max_accel         = LIMIT_W'(DEF_MAX_ACCEL);
		regs.max_decel         = LIMIT_W'(DEF_MAX_DECEL);
		regs.desired_gap       = GAP_W'(DEF_GAP);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: extremes of each field and the stop cases
		add_meas(1'b0, DEF_GAP, 0, 0, 0);
		add_meas(1'b0, DEF_GAP, 0, 65535, 65535);        // big jump ahead, upper clamp
		add_meas(1'b0, 0, 65535, 0, 0);                  // big drop, lower clamp
		add_meas(1'b0, 0, 0, 0, 0);                      // braking at standstill floors at 0
		add_meas(1'b1, 0, 3000, 4000, 3000);             // stop at obstacle, zero word
		add_meas(1'b1, 2, 3000, 4000, 3000);             // just under the stop limit
		add_meas(1'b1, 3, 3000, 4000, 3000);             // at the stop limit, law runs
		add_meas(1'b1, 262143, 65535, 65535, 65535);     // stop mode ignores pred speed
		add_meas(1'b0, 262143, 65535, 65535, 65535);
		add_meas(1'b0, 262143, 65535, 65535, 65535);     // wide gap at top speed saturates
		add_meas(1'b0, 4000, 5120, 5200, 5300);
		add_meas(1'b0, 3500, 5200, 5100, 5000);
		random_ticks(60);

		// every register at one extreme; c1 above one
		write_all(8191, -32768, -32768, -32768, 65535, 32767, 32767, 262143);
		add_meas(1'b0, 262143, 65535, 65535, 65535);
		add_meas(1'b0, 0, 0, 0, 0);
		add_meas(1'b1, 1, 100, 200, 300);
		random_ticks(50);

		// every register at the other extreme: no clamp room, engine frozen
		write_all(0, 32767, 32767, 32767, 0, 0, 0, 0);
		add_meas(1'b0, 262143, 0, 65535, 0);
		add_meas(1'b0, 0, 65535, 0, 65535);
		random_ticks(50);

		// c1 right at one, then random settings
		write_all(4096, DEF_GAIN_SPEED, DEF_GAIN_LEADER, DEF_GAIN_GAP, DEF_ALPHA,
			DEF_MAX_ACCEL, DEF_MAX_DECEL, DEF_GAP);
		random_ticks(55);
		repeat (4) begin
			random_regs();
			random_ticks(55);
		end

		// drain, then allow a little slack for anything stray
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_bad == 0 && cmd_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
